// ----- rtl/uft_pkg.sv -----
// Shared types and constants for the UDP flow table with expiry.
// No dependencies.
`default_nettype none
package uft_pkg;
    localparam int SLOTS = 512;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int NOW_W = 62;
    localparam int EXP_W = NOW_W + 1;
    localparam int LIFE_W = 32;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 32'd600000000;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic [1:0]       opcode;
        logic             family;
        logic [63:0]      local_addr_hi;
        logic [63:0]      local_addr_lo;
        logic [63:0]      remote_addr_hi;
        logic [63:0]      remote_addr_lo;
        logic [15:0]      local_port;
        logic [15:0]      remote_port;
        logic [NOW_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic hit;
        logic answered_lookup;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             family;
        logic [63:0]      local_hi;
        logic [63:0]      local_lo;
        logic [63:0]      remote_hi;
        logic [63:0]      remote_lo;
        logic [15:0]      local_port;
        logic [15:0]      remote_port;
        logic [EXP_W-1:0] expiry;
    } t_entry;

    // scan control handed to the age/match unit
    typedef struct packed {
        logic             active;
        logic [NOW_W-1:0] now;
        logic [EXP_W-1:0] refresh;
    } t_scan_ctl;
endpackage
`default_nettype wire

// ----- rtl/uft_in_if.sv -----
// Item channels: request in, result out.
// Depends on uft_pkg.
`default_nettype none
interface uft_in_if;
    logic               valid;
    logic               ready;
    uft_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface uft_out_if;
    logic               valid;
    logic               ready;
    uft_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/uft_cell.sv -----
// One table slot of the rotating chain: loads on insert, takes its
// neighbor's entry on shift, clears on flush. Depends on uft_pkg.
`default_nettype none
module uft_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_load,
    input  wire             i_shift,
    input  wire             i_clr,
    input  uft_pkg::t_entry i_ins,
    input  uft_pkg::t_entry i_next,
    output uft_pkg::t_entry o_ent
);
    import uft_pkg::*;

    t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_ent.valid <= 1'b0;
        end else if (i_load) begin
            r_ent <= i_ins;
        end else if (i_shift) begin
            r_ent <= i_next;
        end
    end

    assign o_ent = r_ent;
endmodule
`default_nettype wire

// ----- rtl/uft_age_match.sv -----
// Ages and matches the entry leaving the head of the chain.
// Depends on uft_pkg.
`default_nettype none
module uft_age_match (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  uft_pkg::t_scan_ctl i_ctl,
    input  uft_pkg::t_in_item  i_key,
    input  uft_pkg::t_entry    i_ent,
    output uft_pkg::t_entry    o_ent,
    output logic               o_hit
);
    import uft_pkg::*;

    logic        r_found;
    logic        n_found;
    logic [63:0] w_hm;
    logic [63:0] w_lm;
    logic        w_match;
    logic        w_old;

    assign w_hm = i_key.family ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_0000_0000;
    assign w_lm = i_key.family ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;

    assign w_old = i_ent.expiry < {1'b0, i_ctl.now};
    assign w_match = (i_ent.family == i_key.family)
        && (i_ent.local_port == i_key.local_port)
        && (i_ent.remote_port == i_key.remote_port)
        && (((i_ent.local_hi ^ i_key.local_addr_hi) & w_hm) == 64'h0)
        && (((i_ent.remote_hi ^ i_key.remote_addr_hi) & w_hm) == 64'h0)
        && (((i_ent.local_lo ^ i_key.local_addr_lo) & w_lm) == 64'h0)
        && (((i_ent.remote_lo ^ i_key.remote_addr_lo) & w_lm) == 64'h0);

    always_comb begin
        o_ent   = i_ent;
        n_found = r_found;
        if (i_ctl.active && !r_found && i_ent.valid) begin
            if (w_old) begin
                o_ent.valid = 1'b0;
            end else if (w_match) begin
                o_ent.expiry = i_ctl.refresh;
                n_found      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    // includes a match on the slot at the head in this cycle
    assign o_hit = n_found;
endmodule
`default_nettype wire

// ----- rtl/udp_flow_table_with_expiry.sv -----
// Top level: FSM, config register and the rotating chain of slot cells.
// Depends on uft_pkg, uft_in_if, uft_cell, uft_age_match.
// Insert, flush, unused opcode: the result is valid in the cycle after the item is taken.
// Lookup: the ring rotates once through the age/match unit in SLOTS (512) shifts;
// the result is registered at the last shift.
// One item at a time: the next can be taken the cycle after the result leaves.
// Reset (synchronous, active low) clears all valid bits, the pointer,
// the FSM and sets flow_lifetime to 600000000.
`default_nettype none
module udp_flow_table_with_expiry (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [31:0]            i_cfg_wdata,
    uft_in_if.sink                i_in,
    uft_out_if.source             o_out
);
    import uft_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [LIFE_W-1:0]  r_life;
    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   r_cnt;
    t_in_item           r_key;
    logic [EXP_W-1:0]   r_refresh;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               w_acc;
    logic               w_ins;
    logic               w_flush;
    logic               w_start;
    logic               w_shift;
    t_entry             w_new;
    t_entry             w_proc;
    t_entry             w_ent [SLOTS];
    t_scan_ctl          w_ctl;
    logic               w_hit;

    assign w_acc   = i_in.valid && i_in.ready;
    assign w_ins   = w_acc && (i_in.data.opcode == OP_INSERT);
    assign w_flush = w_acc && (i_in.data.opcode == OP_FLUSH);
    assign w_start = w_acc && (i_in.data.opcode == OP_LOOKUP);
    assign w_shift = (r_state == ST_SCAN) || (r_state == ST_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_start) n_state = ST_SCAN;
            ST_SCAN: if (r_cnt == PTR_W'(SLOTS - 2)) n_state = ST_LAST;
            ST_LAST: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == ST_IDLE) && !r_out_valid;
    end

    always_comb begin
        w_new.valid       = 1'b1;
        w_new.family      = i_in.data.family;
        w_new.local_hi    = i_in.data.local_addr_hi;
        w_new.local_lo    = i_in.data.local_addr_lo;
        w_new.remote_hi   = i_in.data.remote_addr_hi;
        w_new.remote_lo   = i_in.data.remote_addr_lo;
        w_new.local_port  = i_in.data.local_port;
        w_new.remote_port = i_in.data.remote_port;
        w_new.expiry      = {1'b0, i_in.data.now} + {{(EXP_W-LIFE_W){1'b0}}, r_life};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_life      <= LIFE_RESET;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_life <= i_cfg_wdata;
            end
            if (w_flush) begin
                r_ptr <= '0;
            end else if (w_ins) begin
                r_ptr <= (r_ptr == PTR_W'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
            end
            if (w_start) begin
                r_cnt <= '0;
            end else if (w_shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if ((w_acc && !w_start) || (r_state == ST_LAST)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_key     <= i_in.data;
            r_refresh <= w_new.expiry;
        end
        if (w_acc && !w_start) begin
            r_out.hit             <= 1'b0;
            r_out.answered_lookup <= 1'b0;
        end else if (r_state == ST_LAST) begin
            r_out.hit             <= w_hit;
            r_out.answered_lookup <= 1'b1;
        end
    end

    assign w_ctl.active  = w_shift;
    assign w_ctl.now     = r_key.now;
    assign w_ctl.refresh = r_refresh;

    uft_age_match u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ctl   (w_ctl),
        .i_key   (r_key),
        .i_ent   (w_ent[0]),
        .o_ent   (w_proc),
        .o_hit   (w_hit)
    );

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            uft_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_ins && (r_ptr == PTR_W'(gi))),
                .i_shift (w_shift),
                .i_clr   (w_flush),
                .i_ins   (w_new),
                .i_next  ((gi == SLOTS - 1) ? w_proc : w_ent[(gi + 1) % SLOTS]),
                .o_ent   (w_ent[gi])
            );
        end
    endgenerate

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_scan_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_out_valid)
        else $error("result pending during scan");
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (r_state == ST_IDLE))
        else $error("item taken while busy");
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAST) |=> (r_out_valid && r_out.answered_lookup))
        else $error("lookup end without result");
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAST) |-> (r_cnt == PTR_W'(SLOTS - 1)))
        else $error("scan length wrong");
`endif
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for udp_flow_table_with_expiry: random and directed insert/lookup/flush
// items checked against an in-bench model of the aging flow table.
// Depends on uft_pkg, uft_in_if/uft_out_if and the RTL top level.
`timescale 1ns / 1ps
module tb;
    import uft_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int SMALL_SET = 12;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    uft_in_if in_ch();
    uft_out_if out_ch();

    udp_flow_table_with_expiry u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // model state
    t_entry flows[SLOTS];
    logic [PTR_W-1:0] ins_ptr;
    logic [LIFE_W-1:0] lifetime;

    t_in_item pending_reqs[$];
    t_out_item expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit drive_on = 1'b0;
    int burst_left = 0, gap_left = 0;
    int stall_phase = 0;
    bit hold_sender = 1'b0;

    // key pool so lookups hit often
    t_in_item keys[SMALL_SET];
    logic [NOW_W-1:0] clock_now;

    function automatic bit key_equal(t_entry e, t_in_item it);
        logic [63:0] hm, lm;
        hm = it.family ? '1 : 64'hFFFF_FFFF_0000_0000;
        lm = it.family ? '1 : '0;
        return e.family == it.family && e.local_port == it.local_port &&
               e.remote_port == it.remote_port &&
               ((e.local_hi ^ it.local_addr_hi) & hm) == 0 &&
               ((e.remote_hi ^ it.remote_addr_hi) & hm) == 0 &&
               ((e.local_lo ^ it.local_addr_lo) & lm) == 0 &&
               ((e.remote_lo ^ it.remote_addr_lo) & lm) == 0;
    endfunction

    function automatic t_out_item apply_flow_op(t_in_item it);
        t_out_item r;
        logic [EXP_W-1:0] exp_t;
        r = '0;
        exp_t = EXP_W'(it.now) + EXP_W'(lifetime);
        case (t_opcode'(it.opcode))
            OP_INSERT: begin
                flows[ins_ptr] = '{valid: 1'b1, family: it.family,
                    local_hi: it.local_addr_hi, local_lo: it.local_addr_lo,
                    remote_hi: it.remote_addr_hi, remote_lo: it.remote_addr_lo,
                    local_port: it.local_port, remote_port: it.remote_port,
                    expiry: exp_t};
                ins_ptr = ins_ptr + 1'b1;
            end
            OP_LOOKUP: begin
                r.answered_lookup = 1'b1;
                for (int s = 0; s < SLOTS; s++) begin
                    if (flows[s].valid && flows[s].expiry < EXP_W'(it.now))
                        flows[s].valid = 1'b0;
                    if (flows[s].valid && key_equal(flows[s], it)) begin
                        flows[s].expiry = exp_t;
                        r.hit = 1'b1;
                        break;
                    end
                end
            end
            OP_FLUSH: begin
                for (int s = 0; s < SLOTS; s++) flows[s].valid = 1'b0;
                ins_ptr = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item random_key();
        t_in_item it;
        it = '0;
        it.family = $urandom_range(0, 1);
        it.local_addr_hi = rand64();
        it.local_addr_lo = rand64();
        it.remote_addr_hi = rand64();
        it.remote_addr_lo = rand64();
        it.local_port = $urandom;
        it.remote_port = $urandom;
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(apply_flow_op(in_ch.data));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (drive_on && !hold_sender && pending_reqs.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_reqs.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 2048 < 512) out_ch.ready <= 1'b1;
            else out_ch.ready <= ((stall_phase * 7) % 11) > 3;
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    if (out_ch.data.hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, out_ch.data.hit);
                        errors++;
                    end
                    if (out_ch.data.answered_lookup !== want.answered_lookup) begin
                        $error("answered_lookup: expected %0b, got %0b",
                               want.answered_lookup, out_ch.data.answered_lookup);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_op(t_opcode op, t_in_item key, logic [NOW_W-1:0] t);
        t_in_item it;
        it = key;
        it.opcode = op;
        it.now = t;
        pending_reqs.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic set_lifetime(logic [31:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lifetime = v;
    endtask

    task automatic random_phase(int n, int span);
        t_in_item k;
        for (int i = 0; i < n; i++) begin
            int pick;
            pick = $urandom_range(0, 99);
            clock_now = clock_now + $urandom_range(0, span);
            if (pick < 3) clock_now = clock_now + NOW_W'(lifetime) + 1;
            k = ($urandom_range(0, 3) == 0) ? random_key() : keys[$urandom_range(0, SMALL_SET-1)];
            if (pick < 40) push_op(OP_INSERT, k, clock_now);
            else if (pick < 93) begin
                // IPv4 lookups with differing low bits still must match
                if (!k.family && $urandom_range(0, 1)) begin
                    k.local_addr_hi[31:0] = $urandom;
                    k.remote_addr_lo = rand64();
                end
                push_op(OP_LOOKUP, k, clock_now);
            end
            else if (pick < 97) push_op(OP_FLUSH, k, clock_now);
            else push_op(OP_NONE, k, clock_now);
        end
    endtask

    initial begin
        t_in_item k;
        for (int s = 0; s < SLOTS; s++) flows[s] = '0;
        ins_ptr = '0;
        lifetime = LIFE_RESET;
        for (int i = 0; i < SMALL_SET; i++) keys[i] = random_key();
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_on = 1'b1;

        // directed: extremes, expiry edge, IPv4 masking, flush, unused opcode
        k = '0;
        push_op(OP_LOOKUP, k, '0);
        push_op(OP_INSERT, k, '0);
        push_op(OP_LOOKUP, k, '0);
        k = '1;
        k.family = 1'b1;
        push_op(OP_INSERT, k, '1 - 64);
        push_op(OP_LOOKUP, k, '1);
        k.local_addr_lo = '0;
        push_op(OP_LOOKUP, k, '1 - 64);
        k = random_key();
        k.family = 1'b0;
        push_op(OP_INSERT, k, 62'd1000);
        k.local_addr_lo = ~k.local_addr_lo;
        k.remote_addr_hi[31:0] = ~k.remote_addr_hi[31:0];
        push_op(OP_LOOKUP, k, 62'd1000 + LIFE_RESET);
        push_op(OP_LOOKUP, k, 62'd1001 + LIFE_RESET + LIFE_RESET);
        push_op(OP_NONE, k, '0);
        push_op(OP_INSERT, k, 62'd5);
        push_op(OP_FLUSH, k, 62'd5);
        push_op(OP_LOOKUP, k, 62'd5);
        clock_now = 62'd100;
        wait_drained();

        set_lifetime(32'd1);
        random_phase(120, 2);
        // hold the sender until everything has come back
        wait (pending_reqs.size() == 0 && !in_ch.valid);
        hold_sender = 1'b1;
        random_phase(10, 2);
        wait (expected_results.size() == 0);
        hold_sender = 1'b0;
        set_lifetime(32'hFFFF_FFFF);
        random_phase(120, 1 << 20);
        set_lifetime(32'd40);
        random_phase(130, 8);
        // overflow the ring pointer
        set_lifetime(32'd100000);
        for (int i = 0; i < SLOTS + 20; i++) push_op(OP_INSERT, random_key(), clock_now);
        random_phase(120, 100);
        wait_drained();
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
